/* rtl/core/pfa_pkg.sv */
// Shared types and constants for the page frame allocator.
package pfa_pkg;
  localparam int unsigned NumRegions = 2;
  localparam int unsigned MaxFrames  = 1024;
  localparam int unsigned PageShift  = 12;
  localparam int unsigned RefWidth   = 16;
  localparam int unsigned AddrWidth  = 40;
  localparam int unsigned IdxWidth   = $clog2(MaxFrames);
  localparam int unsigned CntWidth   = IdxWidth + 1;
  localparam int unsigned RegWidth   = $clog2(NumRegions);
  localparam int unsigned SlotWidth  = RegWidth + IdxWidth;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned PageNumWidth = AddrWidth - PageShift;

  typedef enum logic [1:0] {
    OpInit = 2'd0,
    OpAlloc = 2'd1,
    OpInc = 2'd2,
    OpDec = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CfgR0Base = 3'd0,
    CfgR0Frames = 3'd1,
    CfgR1Base = 3'd2,
    CfgR1Frames = 3'd3,
    CfgResStart = 3'd4,
    CfgResEnd = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StInitChk,
    StInitWr,
    StRead,
    StWrite,
    StDone
  } back_state_e;

  // Classified command from the front part.
  typedef struct packed {
    op_e                  op;
    logic                 hit;
    logic [RegWidth-1:0]  region;
    logic [IdxWidth-1:0]  index;
  } cmd_t;

  typedef struct packed {
    logic                 status;
    logic [AddrWidth-1:0] alloc_address;
    logic                 frame_freed;
  } res_t;
endpackage

/* rtl/core/pfa_if.sv */
// Valid/ready channel interface carrying one payload.
interface pfa_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/page_frame_allocator_refcount_top.sv */
// Top level of the page frame allocator with reference counts.
//
// Usage: requests (opcode, frame_address) enter on req; one result
// (status, alloc_address, frame_freed) leaves on rsp for every request.
// The user must write registers through cfg_we_i/cfg_idx_i/cfg_data_i only
// while idle; the block does not enforce it. The front part resolves an
// address to region and frame index and parks the command in a two-entry
// queue; the back part owns the free-queue and count memories and runs one
// command at a time. Alloc, increment and decrement pass through the back
// part as accept, memory read, write and publish, since each memory is read
// before it is written. Init sweeps every frame with a check and a write,
// plus one further check per region.
// Reset clears queue heads, tails and counts; memories hold garbage until
// an init. A stalled receiver keeps the result in the output register and
// the back part holds the next command until that result leaves; the front
// queue keeps taking up to two requests.
module page_frame_allocator_refcount_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pfa_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [pfa_pkg::AddrWidth-1:0]    cfg_data_i,
  pfa_if.sink                              req,
  pfa_if.source                            rsp
);
  import pfa_pkg::*;

  logic [AddrWidth-1:0] base_q [NumRegions];
  logic [CntWidth-1:0]  frames_q [NumRegions];
  logic [CntWidth-1:0]  frames_c [NumRegions];
  logic [AddrWidth-1:0] res_start_q, res_end_q;
  logic                 cmd_valid, cmd_ready;
  cmd_t                 cmd;
  res_t                 res;

  // Clamp frame counts to the queue size.
  always_comb begin
    for (int r = 0; r < NumRegions; r++) begin
      frames_c[r] = (frames_q[r] > CntWidth'(MaxFrames)) ? CntWidth'(MaxFrames) : frames_q[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegions; r++) begin
        base_q[r] <= '0; frames_q[r] <= '0;
      end
      res_start_q <= '0; res_end_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgR0Base:   base_q[0] <= cfg_data_i;
        CfgR0Frames: frames_q[0] <= cfg_data_i[CntWidth-1:0];
        CfgR1Base:   base_q[1] <= cfg_data_i;
        CfgR1Frames: frames_q[1] <= cfg_data_i[CntWidth-1:0];
        CfgResStart: res_start_q <= cfg_data_i;
        CfgResEnd:   res_end_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pfa_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .opcode_i(req.data.opcode), .frame_address_i(req.data.frame_address),
    .base_i(base_q), .frames_i(frames_c),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  pfa_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .base_i(base_q), .frames_i(frames_c),
    .res_start_i(res_start_q), .res_end_i(res_end_q),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready), .out_o(res)
  );

  assign rsp.data.status = res.status;
  assign rsp.data.alloc_address = res.alloc_address;
  assign rsp.data.frame_freed = res.frame_freed;

`ifndef SYNTH
  a_freed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !(rsp.data.frame_freed && rsp.data.status))
    else $error("freed with error status");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("result dropped under stall");
`endif
endmodule

/* rtl/core/pfa_front.sv */
// Front part: accepts requests, resolves the frame address to region and index.
module pfa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic [pfa_pkg::AddrWidth-1:0] frame_address_i,
  input  logic [pfa_pkg::AddrWidth-1:0] base_i [pfa_pkg::NumRegions],
  input  logic [pfa_pkg::CntWidth-1:0]  frames_i [pfa_pkg::NumRegions],
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output pfa_pkg::cmd_t                 cmd_o
);
  import pfa_pkg::*;

  // Two-entry command queue.
  cmd_t        q_mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  cmd_t        cls;
  logic        push, pop;
  logic [AddrWidth-1:0] diff;
  logic [PageNumWidth-1:0] pg;

  always_comb begin
    cls.op = op_e'(opcode_i);
    cls.hit = 1'b0;
    cls.region = '0;
    cls.index = '0;
    diff = '0;
    pg = '0;
    for (int r = NumRegions - 1; r >= 0; r--) begin
      diff = frame_address_i - base_i[r];
      pg = diff[AddrWidth-1:PageShift];
      if (frame_address_i >= base_i[r] &&
          pg < PageNumWidth'(frames_i[r])) begin
        cls.hit = 1'b1;
        cls.region = RegWidth'(r);
        cls.index = pg[IdxWidth-1:0];
      end
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

/* rtl/core/pfa_back.sv */
// Back part: runs init sweeps and count/queue updates over the frame memories.
module pfa_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  pfa_pkg::cmd_t                 cmd_i,
  input  logic [pfa_pkg::AddrWidth-1:0] base_i [pfa_pkg::NumRegions],
  input  logic [pfa_pkg::CntWidth-1:0]  frames_i [pfa_pkg::NumRegions],
  input  logic [pfa_pkg::AddrWidth-1:0] res_start_i,
  input  logic [pfa_pkg::AddrWidth-1:0] res_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pfa_pkg::res_t                 out_o
);
  import pfa_pkg::*;

  logic [IdxWidth-1:0] fq_mem [NumRegions*MaxFrames];
  logic [RefWidth-1:0] rc_mem [NumRegions*MaxFrames];

  back_state_e state_q, state_d;
  logic [IdxWidth-1:0] head_q [NumRegions];
  logic [IdxWidth-1:0] tail_q [NumRegions];
  logic [CntWidth-1:0] qcnt_q [NumRegions];
  cmd_t                cmd_q;
  logic [RegWidth-1:0] reg_q;
  logic [CntWidth-1:0] j_q;
  logic [AddrWidth:0]  fa_q;
  logic [AddrWidth:0]  x_q;
  logic                resv_q;
  logic [IdxWidth-1:0] fq_rd_q;
  logic [RefWidth-1:0] rc_rd_q;
  logic                out_valid_q;
  res_t                out_q;
  logic                rc_we, fq_we;
  logic [SlotWidth-1:0] rc_wa, fq_wa, rd_slot;
  logic [RefWidth-1:0] rc_wd;
  logic [IdxWidth-1:0] fq_wd;
  logic [RegWidth-1:0] alloc_r;
  logic                alloc_hit;
  logic [AddrWidth-1:0] pmask;
  logic [AddrWidth:0]  x_c;
  logic [PageNumWidth:0] end_pages;
  logic                in_rng, own;
  logic [AddrWidth-1:0] dx;
  logic [PageNumWidth-1:0] pgx;
  logic                take;

  assign pmask = AddrWidth'((64'd1 << PageShift) - 64'd1);
  assign end_pages = {1'b0, res_end_i[AddrWidth-1:PageShift]} +
                     (PageNumWidth+1)'(|(res_end_i & pmask));

  always_comb begin
    alloc_hit = 1'b0;
    alloc_r = '0;
    for (int r = NumRegions - 1; r >= 0; r--) begin
      if (qcnt_q[r] != '0) begin
        alloc_hit = 1'b1;
        alloc_r = RegWidth'(r);
      end
    end
  end

  // Reserved check for frame fa_q of region reg_q, using registered x_q.
  // A frame address past the top of the address space is never reserved.
  always_comb begin
    x_c = fa_q + (({1'b0, res_start_i} - fa_q) & {1'b0, pmask});
    in_rng = !x_q[AddrWidth] && (x_q[AddrWidth-1:0] >= res_start_i) &&
             ({1'b0, x_q[AddrWidth-1:PageShift]} < end_pages);
    own = 1'b0;
    dx = '0;
    pgx = '0;
    for (int r = NumRegions - 1; r >= 0; r--) begin
      dx = x_q[AddrWidth-1:0] - base_i[r];
      pgx = dx[AddrWidth-1:PageShift];
      if (x_q[AddrWidth-1:0] >= base_i[r] && pgx < PageNumWidth'(frames_i[r])) begin
        own = (RegWidth'(r) == reg_q) && (pgx[IdxWidth-1:0] == j_q[IdxWidth-1:0]);
      end
    end
  end

  // Take a command only once the output register is free or leaving.
  assign take = cmd_valid_i && cmd_ready_o;
  assign cmd_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

  always_comb begin
    if (cmd_q.op == OpAlloc) rd_slot = {alloc_r, head_q[alloc_r]};
    else rd_slot = {cmd_q.region, cmd_q.index};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (take) begin
          if (cmd_i.op == OpInit) state_d = StInitChk;
          else state_d = StRead;
        end
      end
      StInitChk: begin
        if (j_q >= frames_i[reg_q]) begin
          if (32'(reg_q) == NumRegions - 1) state_d = StDone;
        end else begin
          state_d = StInitWr;
        end
      end
      StInitWr: state_d = StInitChk;
      StRead: state_d = StWrite;
      StWrite: state_d = StDone;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    rc_we = 1'b0; rc_wa = {reg_q, j_q[IdxWidth-1:0]}; rc_wd = '0;
    fq_we = 1'b0; fq_wa = '0; fq_wd = '0;
    unique case (state_q)
      StInitWr: begin
        rc_we = 1'b1;
        rc_wd = (in_rng && own) ? RefWidth'(1) : '0;
        if (!(in_rng && own)) begin
          fq_we = 1'b1;
          fq_wa = {reg_q, qcnt_q[reg_q][IdxWidth-1:0]};
          fq_wd = j_q[IdxWidth-1:0];
        end
      end
      StWrite: begin
        rc_wa = {cmd_q.region, cmd_q.index};
        if (cmd_q.op == OpInc && cmd_q.hit) begin
          rc_we = (rc_rd_q != '1);
          rc_wd = rc_rd_q + 1'b1;
        end else if (cmd_q.op == OpDec && cmd_q.hit && rc_rd_q != '0) begin
          rc_we = 1'b1;
          rc_wd = rc_rd_q - 1'b1;
          if (rc_rd_q == RefWidth'(1) && qcnt_q[cmd_q.region] < CntWidth'(MaxFrames)) begin
            fq_we = 1'b1;
            fq_wa = {cmd_q.region, tail_q[cmd_q.region]};
            fq_wd = cmd_q.index;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rc_we) rc_mem[rc_wa] <= rc_wd;
    if (fq_we) fq_mem[fq_wa] <= fq_wd;
    rc_rd_q <= rc_mem[rd_slot];
    fq_rd_q <= fq_mem[rd_slot];
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
    if (state_q == StInitChk || state_q == StIdle) x_q <= x_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int r = 0; r < NumRegions; r++) begin
        head_q[r] <= '0; tail_q[r] <= '0; qcnt_q[r] <= '0;
      end
      reg_q <= '0; j_q <= '0; fa_q <= '0; resv_q <= 1'b0;
      out_valid_q <= 1'b0; out_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StDone) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (take && cmd_i.op == OpInit) begin
          reg_q <= '0; j_q <= '0; fa_q <= {1'b0, base_i[0]};
          for (int r = 0; r < NumRegions; r++) begin
            head_q[r] <= '0; qcnt_q[r] <= '0;
          end
          resv_q <= 1'b1;
        end
        StInitChk: begin
          if (j_q >= frames_i[reg_q]) begin
            tail_q[reg_q] <= qcnt_q[reg_q][IdxWidth-1:0];
            if (32'(reg_q) != NumRegions - 1) begin
              reg_q <= reg_q + 1'b1; j_q <= '0; fa_q <= {1'b0, base_i[reg_q + 1'b1]};
            end else begin
              out_q <= '0;
            end
          end else if (resv_q) begin
            // x_q lags one frame; refresh for current frame before writing.
            resv_q <= 1'b0;
          end
        end
        StInitWr: begin
          if (!(in_rng && own)) qcnt_q[reg_q] <= qcnt_q[reg_q] + 1'b1;
          j_q <= j_q + 1'b1;
          fa_q <= fa_q + (AddrWidth+1)'(64'd1 << PageShift);
        end
        StRead: ;
        StWrite: begin
          out_q <= '0;
          unique case (cmd_q.op)
            OpAlloc: begin
              if (alloc_hit) begin
                head_q[alloc_r] <= head_q[alloc_r] + 1'b1;
                qcnt_q[alloc_r] <= qcnt_q[alloc_r] - 1'b1;
                out_q.alloc_address <= base_i[alloc_r] +
                  (AddrWidth'(fq_rd_q) << PageShift);
              end else out_q.status <= 1'b1;
            end
            OpInc: out_q.status <= !cmd_q.hit;
            OpDec: begin
              if (!cmd_q.hit || rc_rd_q == '0) out_q.status <= 1'b1;
              else if (fq_we) begin
                tail_q[cmd_q.region] <= tail_q[cmd_q.region] + 1'b1;
                qcnt_q[cmd_q.region] <= qcnt_q[cmd_q.region] + 1'b1;
                out_q.frame_freed <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        StDone: ;
        default: ;
      endcase
    end
  end
endmodule
